[design/hbf_pkg.sv]
// Package for the bond-force block: payload structs, widths and shared constants.
// Depends on nothing.
`default_nettype none
package hbf_pkg;
   localparam int unsigned FRAC_BITS_DEFAULT = 16;
   localparam int unsigned CFG_W = 31;
   localparam int unsigned DAT_W = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STALL_FORCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HILL_A      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HILL_B      = 2'd3;
   localparam logic [CFG_W-1:0] HILL_B_RESET = 31'd65536;

   typedef struct packed {
      logic signed [DAT_W-1:0] dpos_x;
      logic signed [DAT_W-1:0] dpos_y;
      logic signed [DAT_W-1:0] dpos_z;
      logic signed [DAT_W-1:0] dvel_x;
      logic signed [DAT_W-1:0] dvel_y;
      logic signed [DAT_W-1:0] dvel_z;
      logic                    active;
   } req_type;

   typedef struct packed {
      logic signed [DAT_W-1:0] force_x;
      logic signed [DAT_W-1:0] force_y;
      logic signed [DAT_W-1:0] force_z;
      logic                    vel_clamped;
      logic signed [DAT_W-1:0] clamp_vel_x;
      logic signed [DAT_W-1:0] clamp_vel_y;
      logic signed [DAT_W-1:0] clamp_vel_z;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] stall_force;
      logic [CFG_W-1:0] max_speed;
      logic [CFG_W-1:0] hill_a;
      logic [CFG_W-1:0] hill_b;
   } cfg_type;
endpackage
`default_nettype wire

[design/hill_bond_force.sv]
// Top level of the bond-force block: front end, square root, divider chain and result.
// Depends on hbf_pkg, hbf_sqrt_pipe and hbf_div_pipe.
//
// Usage: pulse start with a bond on req_data; busy is never high, so one bond
// is taken in every cycle. Each bond gives exactly one result on rsp_data,
// marked by rsp_valid for a single cycle, in order of entry. From the
// accepting edge to rsp_valid a bond passes the squaring and dot-product
// register, the sum register, 33 square-root stages, 64 stages for the
// closing-speed divide, a mode and multiply stage, 64 stages for the Hill
// divide, a subtract stage and a multiply stage, three parallel 64-stage
// divides for the per-axis quotients, then one output register. Throughput
// is one bond per clock, set by the fully pipelined square root and
// dividers. The configuration registers are written through
// csr_valid/csr_ready (ready is always high) and must only change while no
// transaction is in flight. Reset clears all valid bits and loads the
// register reset values; results in flight are dropped. The receiver cannot
// stall, so no back-pressure exists anywhere in the pipeline.
`default_nettype none
module hill_bond_force
   import hbf_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [CSR_IDX_W-1:0]     csr_index,
   input  wire [CFG_W-1:0]         csr_wdata
);
   // Q format is carried by scale alone; FRAC_BITS does not set it, but a zero value blocks register writes.
   localparam int unsigned FB_CHECK = FRAC_BITS;
   localparam int unsigned QW = 64;

   cfg_type cfg_ff;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_force <= '0;
         cfg_ff.max_speed   <= '0;
         cfg_ff.hill_a      <= '0;
         cfg_ff.hill_b      <= HILL_B_RESET;
      end else if (csr_valid && FB_CHECK > 0) begin
         case (csr_index)
            CSR_STALL_FORCE: cfg_ff.stall_force <= csr_wdata;
            CSR_MAX_SPEED:   cfg_ff.max_speed   <= csr_wdata;
            CSR_HILL_A:      cfg_ff.hill_a      <= csr_wdata;
            CSR_HILL_B:      cfg_ff.hill_b      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Tag carried along the whole pipeline.
   typedef struct packed {
      logic [2:0]    dpos;
      logic [31:0]   dm_x;
      logic [31:0]   dm_y;
      logic [31:0]   dm_z;
      logic          active;
      logic          shorten;
      logic [63:0]   dotmag;
   } tag_type;
   localparam int unsigned TW = $bits(tag_type);

   // Stage 1: magnitudes and products.
   logic          s1_valid_ff;
   logic [31:0]   s1_dm_ff [3];
   logic [2:0]    s1_pos_ff;
   logic [63:0]   s1_sq_ff [3];
   logic signed [63:0] s1_p_ff [3];
   logic          s1_act_ff;
   logic signed [31:0] din [3];
   logic signed [31:0] vin [3];
   assign din[0] = req_data.dpos_x;  assign vin[0] = req_data.dvel_x;
   assign din[1] = req_data.dpos_y;  assign vin[1] = req_data.dvel_y;
   assign din[2] = req_data.dpos_z;  assign vin[2] = req_data.dvel_z;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start;
      s1_act_ff <= req_data.active;
      for (int i = 0; i < 3; i++) begin
         s1_dm_ff[i]  <= din[i][31] ? 32'(-din[i]) : 32'(din[i]);
         s1_pos_ff[i] <= !din[i][31] && (din[i] != 0);
         s1_sq_ff[i]  <= 64'(din[i]) * 64'(din[i]);
         s1_p_ff[i]   <= 64'(din[i]) * 64'(vin[i]);
      end
   end

   // Stage 2: sums.
   logic          s2_valid_ff;
   logic [65:0]   s2_rsq_ff;
   tag_type       s2_tag_ff;
   logic signed [65:0] dot_in;
   assign dot_in = 66'(s1_p_ff[0]) + 66'(s1_p_ff[1]) + 66'(s1_p_ff[2]);
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_rsq_ff <= 66'(s1_sq_ff[0]) + 66'(s1_sq_ff[1]) + 66'(s1_sq_ff[2]);
      s2_tag_ff.dpos    <= s1_pos_ff;
      s2_tag_ff.dm_x    <= s1_dm_ff[0];
      s2_tag_ff.dm_y    <= s1_dm_ff[1];
      s2_tag_ff.dm_z    <= s1_dm_ff[2];
      s2_tag_ff.active  <= s1_act_ff;
      s2_tag_ff.shorten <= dot_in[65];
      s2_tag_ff.dotmag  <= dot_in[65] ? 64'(-dot_in) : 64'(dot_in);
   end

   // Square root.
   logic          sq_valid;
   logic [32:0]   sq_root;
   logic [TW-1:0] sq_tag_raw;
   hbf_sqrt_pipe #(.IN_W(66), .TAG_W(TW)) u_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(s2_valid_ff), .in_val(s2_rsq_ff), .in_tag(s2_tag_ff),
      .out_valid(sq_valid), .out_root(sq_root), .out_tag(sq_tag_raw)
   );
   tag_type sq_tag;
   assign sq_tag = tag_type'(sq_tag_raw);

   // Closing-speed divide; r travels with the tag.
   typedef struct packed {
      tag_type       t;
      logic [32:0]   r;
   } tr_type;
   localparam int unsigned TRW = $bits(tr_type);
   tr_type        sq_tr;
   assign sq_tr.t = sq_tag;
   assign sq_tr.r = sq_root;

   logic          vs_valid;
   logic [QW-1:0] vs_quot;
   logic [TRW-1:0] vs_tag_raw;
   hbf_div_pipe #(.NUM_W(QW), .DEN_W(33), .TAG_W(TRW)) u_div_speed (
      .clock(clock), .reset(reset),
      .in_valid(sq_valid), .in_num(sq_tag.dotmag),
      .in_den((sq_root == 0) ? 33'd1 : sq_root), .in_tag(sq_tr),
      .out_valid(vs_valid), .out_quot(vs_quot), .out_tag(vs_tag_raw)
   );
   tr_type vs_tr;
   assign vs_tr = tr_type'(vs_tag_raw);

   // Mode decision and Hill numerator.
   localparam logic [1:0] MODE_ZERO   = 2'd0;
   localparam logic [1:0] MODE_CLAMP  = 2'd1;
   localparam logic [1:0] MODE_HILL   = 2'd2;
   localparam logic [1:0] MODE_STALL  = 2'd3;
   typedef struct packed {
      tr_type        tr;
      logic [1:0]    mode;
   } md_type;
   localparam int unsigned MDW = $bits(md_type);

   logic          m_valid_ff;
   md_type        m_md_ff;
   logic [63:0]   m_num_ff;
   logic [64:0]   m_den_ff;
   logic [1:0]    mode_in;
   always_comb begin
      if (!vs_tr.t.active || vs_tr.r == 0)                        mode_in = MODE_ZERO;
      else if (!vs_tr.t.shorten || vs_tr.t.dotmag == 0)           mode_in = MODE_STALL;
      else if (vs_quot > 64'(cfg_ff.max_speed))                   mode_in = MODE_CLAMP;
      else                                                        mode_in = MODE_HILL;
   end
   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else       m_valid_ff <= vs_valid;
      m_md_ff.tr   <= vs_tr;
      m_md_ff.mode <= mode_in;
      m_num_ff     <= 64'(cfg_ff.hill_b) * 64'(32'(cfg_ff.hill_a) + 32'(cfg_ff.stall_force));
      m_den_ff     <= 65'(vs_quot) + 65'(cfg_ff.hill_b);
   end
   // vshort is at most about 2^33, so the denominator fits 64 bits.
   logic          h_valid;
   logic [QW-1:0] h_quot;
   logic [MDW-1:0] h_tag_raw;
   logic          den_zero;
   assign den_zero = (m_den_ff == 0);
   hbf_div_pipe #(.NUM_W(QW), .DEN_W(35), .TAG_W(MDW)) u_div_hill (
      .clock(clock), .reset(reset),
      .in_valid(m_valid_ff), .in_num(den_zero ? 64'd0 : m_num_ff),
      .in_den(den_zero ? 35'd1 : m_den_ff[34:0]), .in_tag(m_md_ff),
      .out_valid(h_valid), .out_quot(h_quot), .out_tag(h_tag_raw)
   );
   md_type h_md;
   assign h_md = md_type'(h_tag_raw);

   // Coefficient G (V0 for clamp, stall force for stall, zero otherwise), sign and magnitude.
   logic          g_valid_ff;
   md_type        g_md_ff;
   logic [32:0]   g_mag_ff;
   logic          g_neg_ff;
   logic signed [65:0] g_in;
   assign g_in = $signed({2'b00, h_quot}) - $signed(66'(cfg_ff.hill_a));
   always_ff @(posedge clock) begin
      if (reset) g_valid_ff <= 1'b0;
      else       g_valid_ff <= h_valid;
      g_md_ff <= h_md;
      case (h_md.mode)
         MODE_HILL: begin
            g_neg_ff <= g_in[65];
            g_mag_ff <= g_in[65] ? 33'(-g_in) : 33'(g_in);
         end
         MODE_CLAMP: begin
            g_neg_ff <= 1'b0;
            g_mag_ff <= 33'(cfg_ff.max_speed);
         end
         MODE_STALL: begin
            g_neg_ff <= 1'b0;
            g_mag_ff <= 33'(cfg_ff.stall_force);
         end
         default: begin
            g_neg_ff <= 1'b0;
            g_mag_ff <= '0;
         end
      endcase
   end

   // Products per axis.
   logic          p_valid_ff;
   md_type        p_md_ff;
   logic          p_gneg_ff;
   logic [63:0]   p_prod_ff [3];
   logic [31:0]   dmv [3];
   assign dmv[0] = g_md_ff.tr.t.dm_x;
   assign dmv[1] = g_md_ff.tr.t.dm_y;
   assign dmv[2] = g_md_ff.tr.t.dm_z;
   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else       p_valid_ff <= g_valid_ff;
      p_md_ff   <= g_md_ff;
      p_gneg_ff <= g_neg_ff;
      for (int i = 0; i < 3; i++) p_prod_ff[i] <= 64'(dmv[i]) * 64'(g_mag_ff);
   end

   typedef struct packed {
      md_type        md;
      logic          gneg;
   } fin_type;
   localparam int unsigned FW = $bits(fin_type);
   fin_type       p_fin;
   assign p_fin.md   = p_md_ff;
   assign p_fin.gneg = p_gneg_ff;
   logic [32:0]   p_den;
   assign p_den = (p_md_ff.tr.r == 0) ? 33'd1 : p_md_ff.tr.r;

   logic          q_valid [3];
   logic [QW-1:0] q_quot  [3];
   logic [FW-1:0] q_tag   [3];
   for (genvar i = 0; i < 3; i++) begin : g_axis
      hbf_div_pipe #(.NUM_W(QW), .DEN_W(33), .TAG_W(FW)) u_div_axis (
         .clock(clock), .reset(reset),
         .in_valid(p_valid_ff), .in_num(p_prod_ff[i]), .in_den(p_den),
         .in_tag(p_fin),
         .out_valid(q_valid[i]), .out_quot(q_quot[i]), .out_tag(q_tag[i])
      );
   end
   fin_type q_fin;
   assign q_fin = fin_type'(q_tag[0]);

   // Output register with sign and saturation.
   logic [31:0] field_in [3];
   logic        fneg [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (q_fin.md.mode == MODE_HILL)
            fneg[i] = q_fin.md.tr.t.dpos[i] != q_fin.gneg;
         else
            fneg[i] = q_fin.md.tr.t.dpos[i];
         if (fneg[i])
            field_in[i] = (q_quot[i] >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q_quot[i]);
         else
            field_in[i] = (q_quot[i] >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_quot[i][31:0];
      end
   end

   rsp_type     rsp_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   always_comb begin
      rsp_in = '0;
      case (q_fin.md.mode)
         MODE_CLAMP: begin
            rsp_in.vel_clamped = 1'b1;
            rsp_in.clamp_vel_x = field_in[0];
            rsp_in.clamp_vel_y = field_in[1];
            rsp_in.clamp_vel_z = field_in[2];
         end
         MODE_HILL, MODE_STALL: begin
            rsp_in.force_x = field_in[0];
            rsp_in.force_y = field_in[1];
            rsp_in.force_z = field_in[2];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= q_valid[0];
      rsp_data_ff <= rsp_in;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The three axis dividers run in lock step.
   assert property (@(posedge clock) disable iff (reset)
      q_valid[0] == q_valid[1] && q_valid[1] == q_valid[2])
      else $error("axis dividers out of step");
   // A clamped result never carries a force.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vel_clamped |->
      rsp_data.force_x == 0 && rsp_data.force_y == 0 && rsp_data.force_z == 0)
      else $error("clamped result with nonzero force");
   // A result always comes from the last divider stage.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(q_valid[0]))
      else $error("result without a finished divide");
endmodule
`default_nettype wire

[design/hbf_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per stage, remainder carried forward.
// Depends on hbf_pkg for nothing but house style; generic widths.
`default_nettype none
module hbf_div_pipe
   import hbf_pkg::*;
#(
   parameter int unsigned NUM_W = 64,
   parameter int unsigned DEN_W = 33,
   parameter int unsigned TAG_W = 1
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   input  wire [NUM_W-1:0]    in_num,
   input  wire [DEN_W-1:0]    in_den,
   input  wire [TAG_W-1:0]    in_tag,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_quot,
   output logic [TAG_W-1:0]   out_tag
);
   // Stage k decides quotient bit NUM_W-1-k; register k+1 holds its outcome.
   logic                   valid_ff [1:NUM_W];
   logic [NUM_W-1:0]       num_ff   [1:NUM_W];
   logic [DEN_W:0]         rem_ff   [1:NUM_W-1];
   logic [DEN_W-1:0]       den_ff   [1:NUM_W-1];
   logic [TAG_W-1:0]       tag_ff   [1:NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             valid_cur;
      logic [NUM_W-1:0] num_cur;
      logic [DEN_W:0]   rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [TAG_W-1:0] tag_cur;
      logic [DEN_W+1:0] trial_in;
      logic [NUM_W-1:0] num_in;
      logic [DEN_W:0]   rem_in;
      if (k == 0) begin : g_head
         assign valid_cur = in_valid;
         assign num_cur   = in_num;
         assign rem_cur   = '0;
         assign den_cur   = in_den;
         assign tag_cur   = in_tag;
      end else begin : g_body
         assign valid_cur = valid_ff[k];
         assign num_cur   = num_ff[k];
         assign rem_cur   = rem_ff[k];
         assign den_cur   = den_ff[k];
         assign tag_cur   = tag_ff[k];
      end
      always_comb begin
         trial_in = {rem_cur, num_cur[NUM_W-1]};
         num_in   = {num_cur[NUM_W-2:0], 1'b0};
         if (trial_in >= {2'b00, den_cur}) begin
            rem_in    = (DEN_W+1)'(trial_in - {2'b00, den_cur});
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial_in[DEN_W:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else       valid_ff[k+1] <= valid_cur;
         num_ff[k+1] <= num_in;
         tag_ff[k+1] <= tag_cur;
      end
      if (k < NUM_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= rem_in;
            den_ff[k+1] <= den_cur;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot  = num_ff[NUM_W];
   assign out_tag   = tag_ff[NUM_W];
endmodule
`default_nettype wire

[design/hbf_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on hbf_pkg only for house style.
`default_nettype none
module hbf_sqrt_pipe
   import hbf_pkg::*;
#(
   parameter int unsigned IN_W  = 66,
   parameter int unsigned TAG_W = 1
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  wire [IN_W-1:0]      in_val,
   input  wire [TAG_W-1:0]     in_tag,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [TAG_W-1:0]    out_tag
);
   localparam int unsigned RW = IN_W / 2;
   logic               valid_ff [1:RW];
   logic [IN_W-1:0]    val_ff   [1:RW-1];
   logic [RW+1:0]      rem_ff   [1:RW-1];
   logic [RW-1:0]      root_ff  [1:RW];
   logic [TAG_W-1:0]   tag_ff   [1:RW];

   // Digit-by-digit: bring down two bits, try 4*root+1.
   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic             valid_cur;
      logic [IN_W-1:0]  val_cur;
      logic [RW+1:0]    rem_cur;
      logic [RW-1:0]    root_cur;
      logic [TAG_W-1:0] tag_cur;
      logic [RW+3:0]    cur_in;
      logic [RW+3:0]    try_in;
      logic [RW+1:0]    rem_in;
      logic [RW-1:0]    root_in;
      if (k == 0) begin : g_head
         assign valid_cur = in_valid;
         assign val_cur   = in_val;
         assign rem_cur   = '0;
         assign root_cur  = '0;
         assign tag_cur   = in_tag;
      end else begin : g_body
         assign valid_cur = valid_ff[k];
         assign val_cur   = val_ff[k];
         assign rem_cur   = rem_ff[k];
         assign root_cur  = root_ff[k];
         assign tag_cur   = tag_ff[k];
      end
      always_comb begin
         cur_in  = {rem_cur, val_cur[IN_W-1 -: 2]};
         try_in  = {2'b00, root_cur, 2'b01};
         root_in = {root_cur[RW-2:0], 1'b0};
         if (cur_in >= try_in) begin
            rem_in     = (RW+2)'(cur_in - try_in);
            root_in[0] = 1'b1;
         end else begin
            rem_in = cur_in[RW+1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else       valid_ff[k+1] <= valid_cur;
         root_ff[k+1] <= root_in;
         tag_ff[k+1]  <= tag_cur;
      end
      if (k < RW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            val_ff[k+1] <= {val_cur[IN_W-3:0], 2'b00};
            rem_ff[k+1] <= rem_in;
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_tag   = tag_ff[RW];
endmodule
`default_nettype wire

[tb/sv/hill_bond_force_tb.sv]
// Self-checking testbench for hill_bond_force: directed and random bonds with a
// scoreboard that predicts each force result. Depends on hbf_pkg and the RTL.
`timescale 1ns / 100ps
module hill_bond_force_tb;
   import hbf_pkg::*;

   localparam int unsigned FRAC = 16;
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam logic [CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;

   class force_scoreboard;
      rsp_type pending_forces[$];
      longint unsigned stall_force, max_speed, hill_a, hill_b;
      int errors;

      function new();
         stall_force = 0;
         max_speed = 0;
         hill_a = 0;
         hill_b = 65536;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_STALL_FORCE: stall_force = val;
            CSR_MAX_SPEED:   max_speed = val;
            CSR_HILL_A:      hill_a = val;
            CSR_HILL_B:      hill_b = val;
            default: ;
         endcase
      endfunction

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // Truncated magnitude quotient with the sign applied afterwards, saturated.
      function logic [31:0] axis_quotient(bit neg, longint unsigned m, longint unsigned r);
         longint unsigned q;
         q = m / r;
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         if (neg) return 32'(-longint'(q));
         if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return 32'(q);
      endfunction

      function void note_bond(req_type b);
         rsp_type e;
         longint signed d[3], v[3], p, g;
         longint unsigned dm[3], rsq, r, pos, neg, vshort, den, term, gm;
         e = '0;
         d[0] = b.dpos_x; d[1] = b.dpos_y; d[2] = b.dpos_z;
         v[0] = b.dvel_x; v[1] = b.dvel_y; v[2] = b.dvel_z;
         rsq = 0;
         pos = 0;
         neg = 0;
         for (int i = 0; i < 3; i++) begin
            dm[i] = d[i] < 0 ? -d[i] : d[i];
            rsq += dm[i] * dm[i];
         end
         r = root_floor(rsq);
         if (b.active && r != 0) begin
            for (int i = 0; i < 3; i++) begin
               p = d[i] * v[i];
               if (p < 0) neg += -p;
               else pos += p;
            end
            if (neg > pos) begin
               vshort = (neg - pos) / r;
               if (vshort > max_speed) begin
                  e.vel_clamped = 1'b1;
                  e.clamp_vel_x = axis_quotient(d[0] > 0, dm[0] * max_speed, r);
                  e.clamp_vel_y = axis_quotient(d[1] > 0, dm[1] * max_speed, r);
                  e.clamp_vel_z = axis_quotient(d[2] > 0, dm[2] * max_speed, r);
               end else begin
                  den = vshort + hill_b;
                  term = den != 0 ? (hill_b * (hill_a + stall_force)) / den : 0;
                  g = longint'(term) - longint'(hill_a);
                  gm = g < 0 ? -g : g;
                  e.force_x = axis_quotient((d[0] > 0) != (g < 0), dm[0] * gm, r);
                  e.force_y = axis_quotient((d[1] > 0) != (g < 0), dm[1] * gm, r);
                  e.force_z = axis_quotient((d[2] > 0) != (g < 0), dm[2] * gm, r);
               end
            end else begin
               e.force_x = axis_quotient(d[0] > 0, dm[0] * stall_force, r);
               e.force_y = axis_quotient(d[1] > 0, dm[1] * stall_force, r);
               e.force_z = axis_quotient(d[2] > 0, dm[2] * stall_force, r);
            end
         end
         pending_forces.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending_forces.size() == 0) begin
            errors++;
            $display("%0t: unexpected result expected none actual %h", $time, a);
            return;
         end
         e = pending_forces.pop_front();
         compare_field("force_x", e.force_x, a.force_x);
         compare_field("force_y", e.force_y, a.force_y);
         compare_field("force_z", e.force_z, a.force_z);
         compare_field("vel_clamped", 32'(e.vel_clamped), 32'(a.vel_clamped));
         compare_field("clamp_vel_x", e.clamp_vel_x, a.clamp_vel_x);
         compare_field("clamp_vel_y", e.clamp_vel_y, a.clamp_vel_y);
         compare_field("clamp_vel_z", e.clamp_vel_z, a.clamp_vel_z);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STALL_FORCE;
   logic [CFG_W-1:0] csr_wdata = '0;

   force_scoreboard sb = new();
   int idle_pct = 0;
   int quiet_cycles = 0;

   hill_bond_force #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Monitors sample before the block's own updates land at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_bond(req_data);
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_wdata);
         if (rsp_valid) sb.check_result(rsp_data);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_bond(req_type b);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= b;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Let every expected result arrive, then allow for the pipeline depth.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_forces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [CFG_W-1:0] f0, logic [CFG_W-1:0] v0,
                            logic [CFG_W-1:0] a, logic [CFG_W-1:0] b);
      drain();
      write_register(CSR_STALL_FORCE, f0);
      write_register(CSR_MAX_SPEED, v0);
      write_register(CSR_HILL_A, a);
      write_register(CSR_HILL_B, b);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value(int span);
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2:       return 32'd0;
         default: return 32'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   function automatic req_type make_bond(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                         logic act);
      req_type b;
      b.dpos_x = px; b.dpos_y = py; b.dpos_z = pz;
      b.dvel_x = vx; b.dvel_y = vy; b.dvel_z = vz;
      b.active = act;
      return b;
   endfunction

   // Bonds at a small or a full-range scale; some are made to close along the bond axis.
   function automatic req_type random_bond();
      req_type b;
      int span, k;
      span = $urandom_range(1) ? (4 << FRAC) : 32'h7FFF_0000;
      b = make_bond(pick_value(span), pick_value(span), pick_value(span),
                    pick_value(span), pick_value(span), pick_value(span),
                    $urandom_range(9) != 0);
      if ($urandom_range(2) == 0) begin
         k = $urandom_range(64);
         b.dvel_x = -((b.dpos_x >>> 6) * k);
         b.dvel_y = -((b.dpos_y >>> 6) * k);
         b.dvel_z = -((b.dpos_z >>> 6) * k);
      end
      return b;
   endfunction

   task automatic run_random(int count);
      repeat (count) send_bond(random_bond());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed bonds under the reset register values, then a typical set.
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1)
            configure(CFG_W'(2 << FRAC), CFG_W'(1 << FRAC), CFG_W'(1 << 14),
                      CFG_W'(1 << FRAC));
         send_bond(make_bond(32'h0001_0000, 0, 0, 0, 0, 0, 1'b0));        // inactive
         send_bond(make_bond(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 1'b1));        // zero length
         send_bond(make_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
         send_bond(make_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
         send_bond(make_bond(32'h0003_0000, 32'hFFFC_0000, 0,
                             32'h0001_0000, 0, 0, 1'b1));                  // extending
         send_bond(make_bond(32'h0002_0000, 0, 0, 32'hFFFF_8000, 0, 0, 1'b1)); // slow close
         send_bond(make_bond(32'h0002_0000, 0, 32'h0001_0000,
                             32'hFFF0_0000, 0, 32'hFFF8_0000, 1'b1));      // fast close
         send_bond(make_bond(100, 99, 0, 32'hFFFF_FFFF, 1, 0, 1'b1));    // near-zero speed
         send_bond(make_bond(1, 0, 0, 32'h8000_0000, 0, 0, 1'b1));
      end

      // No shortening allowed and a zero Hill b: every bond with a nonzero closing speed clamps.
      configure(CFG_MAX, 0, 0, 0);
      send_bond(make_bond(100, 99, 0, 32'hFFFF_FFFF, 1, 0, 1'b1));
      send_bond(make_bond(32'h0002_0000, 0, 0, 32'hFFFF_0000, 0, 0, 1'b1));
      run_random(150);

      // Zero b with unlimited speed: zero denominator and negative Hill force.
      configure(1, CFG_MAX, CFG_MAX, 0);
      send_bond(make_bond(100, 99, 0, 32'hFFFF_FFFF, 1, 0, 1'b1));
      send_bond(make_bond(32'h0002_0000, 0, 0, 32'hFFFF_8000, 0, 0, 1'b1));
      idle_pct = 55;
      run_random(150);

      configure(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
      idle_pct = 0;
      run_random(150);

      configure(CFG_W'(5 << FRAC), CFG_W'(3 << FRAC), CFG_W'(1 << FRAC), CFG_W'(2 << FRAC));
      idle_pct = 32;
      run_random(180);

      configure(CFG_W'($urandom()), CFG_W'($urandom_range(1 << 20)),
                CFG_W'($urandom_range(1 << 18)), CFG_W'($urandom_range(1, 1 << 18)));
      idle_pct = 55;
      run_random(100);
      idle_pct = 0;
      run_random(80);

      drain();
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
